// File: hw/rtl/lkv_pkg.sv
// Shared types and constants for the LRU key-value cache.
`default_nettype none
package lkv_pkg;

   localparam int KEY_WIDTH   = 32;
   localparam int VALUE_WIDTH = 32;
   localparam int CAP_WIDTH   = 5;

   localparam logic CMD_GET = 1'b0;
   localparam logic CMD_PUT = 1'b1;

   localparam logic [CAP_WIDTH-1:0] CAP_RESET = 5'd16;

   typedef struct packed {
      logic                          cmd;
      logic signed [KEY_WIDTH-1:0]   lookup_key;
      logic signed [VALUE_WIDTH-1:0] write_value;
   } req_type;

   typedef struct packed {
      logic                          hit;
      logic signed [VALUE_WIDTH-1:0] read_value;
      logic                          evicted;
   } rsp_type;

   typedef struct packed {
      logic load;     // capture an accepted request beat
      logic capture;  // register the lookup results
      logic commit;   // apply the update and load the response register
   } ctl_type;

endpackage
`default_nettype wire

// File: hw/rtl/lkv_ctrl.sv
// Controller state machine sequencing lookup and update of the LRU cache.
`default_nettype none
module lkv_ctrl (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output logic                  req_stall,
   output logic                  rsp_valid,
   input  wire logic             rsp_stall,
   output lkv_pkg::ctl_type      ctl
);

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_MATCH,
      ST_COMMIT
   } state_type;

   state_type state_ff;
   logic      rsp_valid_ff;
   logic      go;
   logic      accept;

   // The commit may proceed when the response register is empty or is drained this cycle.
   assign go        = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !((state_ff == ST_IDLE) || ((state_ff == ST_COMMIT) && go));
   assign accept    = req_valid && !req_stall;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      ctl.load    = accept;
      ctl.capture = (state_ff == ST_MATCH);
      ctl.commit  = (state_ff == ST_COMMIT) && go;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            ST_IDLE: begin
               if (accept) state_ff <= ST_MATCH;
            end
            ST_MATCH: begin
               state_ff <= ST_COMMIT;
            end
            ST_COMMIT: begin
               if (go) state_ff <= accept ? ST_MATCH : ST_IDLE;
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase

         if ((state_ff == ST_COMMIT) && go) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

endmodule
`default_nettype wire

// File: hw/rtl/lkv_datapath.sv
// Datapath of the LRU cache: entry cells, key compare, recency ranks and response register.
`default_nettype none
module lkv_datapath #(
   parameter int DEPTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire lkv_pkg::ctl_type                ctl,
   input  wire lkv_pkg::req_type                req_data,
   output lkv_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_write,
   input  wire logic [lkv_pkg::CAP_WIDTH-1:0]   csr_data
);

   localparam int IW   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW   = $clog2(DEPTH + 1);
   localparam int CAPW = (CW > lkv_pkg::CAP_WIDTH) ? CW : lkv_pkg::CAP_WIDTH;

   lkv_pkg::req_type                      req_ff;
   lkv_pkg::rsp_type                      rsp_ff;
   logic [lkv_pkg::CAP_WIDTH-1:0]         cap_ff;
   logic [lkv_pkg::KEY_WIDTH-1:0]         key_ff   [DEPTH];
   logic [lkv_pkg::VALUE_WIDTH-1:0]       value_mem[DEPTH];
   logic [DEPTH-1:0]                      valid_ff;
   logic [IW-1:0]                         rank_ff  [DEPTH];
   logic [CW-1:0]                         count_ff;

   logic                                  hit_ff;
   logic                                  ins_ff;
   logic                                  evict_ff;
   logic [IW-1:0]                         slot_ff;
   logic [IW-1:0]                         hrank_ff;
   logic [lkv_pkg::VALUE_WIDTH-1:0]       rd_ff;

   logic [DEPTH-1:0]                      match;
   logic                                  any_match;
   logic                                  hit_found;
   logic                                  free_found;
   logic [IW-1:0]                         hit_idx;
   logic [IW-1:0]                         lru_idx;
   logic [IW-1:0]                         free_idx;
   logic [IW-1:0]                         oldest_rank;
   logic [CAPW-1:0]                       cap_eff;
   logic                                  full;
   logic                                  is_put;

   assign is_put      = (req_ff.cmd == lkv_pkg::CMD_PUT);
   assign oldest_rank = IW'(count_ff - CW'(1));

   always_comb begin
      cap_eff = CAPW'(cap_ff);
      if (cap_eff == '0) cap_eff = CAPW'(1);
      if (cap_eff > CAPW'(DEPTH)) cap_eff = CAPW'(DEPTH);
   end

   assign full = (CAPW'(count_ff) >= cap_eff);

   // Parallel key compare and the lowest-index encoders for match and free slot.
   always_comb begin
      hit_found  = 1'b0;
      free_found = 1'b0;
      hit_idx    = '0;
      free_idx   = '0;
      lru_idx    = '0;
      for (int i = 0; i < DEPTH; i++) begin
         match[i] = valid_ff[i] && (key_ff[i] == req_ff.lookup_key);
         if (match[i] && !hit_found) begin
            hit_found = 1'b1;
            hit_idx   = IW'(i);
         end
         if (!valid_ff[i] && !free_found) begin
            free_found = 1'b1;
            free_idx   = IW'(i);
         end
         // Valid ranks always form 0 to count-1, so the oldest entry holds count-1.
         if (valid_ff[i] && (rank_ff[i] == oldest_rank)) begin
            lru_idx = IW'(i);
         end
      end
   end

   assign any_match = |match;

   always_ff @(posedge clock) begin
      if (ctl.load) req_ff <= req_data;
      if (ctl.capture) begin
         hit_ff   <= any_match;
         ins_ff   <= !any_match && is_put;
         evict_ff <= !any_match && is_put && full;
         hrank_ff <= rank_ff[hit_idx];
         if (any_match) begin
            slot_ff <= hit_idx;
         end else begin
            slot_ff <= full ? lru_idx : free_idx;
         end
      end
   end

   // Entry values: one write port and one registered read port.
   always_ff @(posedge clock) begin
      if (ctl.capture) rd_ff <= value_mem[hit_idx];
      if (ctl.commit && is_put && (hit_ff || ins_ff)) begin
         value_mem[slot_ff] <= req_ff.write_value;
      end
   end

   always_ff @(posedge clock) begin
      if (ctl.commit && ins_ff) key_ff[slot_ff] <= req_ff.lookup_key;
      if (ctl.commit) begin
         rsp_ff.hit        <= hit_ff;
         rsp_ff.read_value <= (hit_ff && !is_put) ? rd_ff : '0;
         rsp_ff.evicted    <= evict_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff   <= lkv_pkg::CAP_RESET;
         valid_ff <= '0;
         count_ff <= '0;
         for (int i = 0; i < DEPTH; i++) rank_ff[i] <= '0;
      end else begin
         if (csr_write) cap_ff <= csr_data;
         if (ctl.commit) begin
            if (hit_ff) begin
               // Entries more recent than the touched one age by one.
               for (int i = 0; i < DEPTH; i++) begin
                  if (valid_ff[i] && (IW'(i) != slot_ff) && (rank_ff[i] < hrank_ff)) begin
                     rank_ff[i] <= rank_ff[i] + IW'(1);
                  end
               end
               rank_ff[slot_ff] <= '0;
            end else if (ins_ff) begin
               // Every other entry ages; an evicted slot is reused for the new pair.
               for (int i = 0; i < DEPTH; i++) begin
                  if (valid_ff[i] && (IW'(i) != slot_ff)) begin
                     rank_ff[i] <= rank_ff[i] + IW'(1);
                  end
               end
               rank_ff[slot_ff]  <= '0;
               valid_ff[slot_ff] <= 1'b1;
               if (!evict_ff) count_ff <= count_ff + CW'(1);
            end
         end
      end
   end

   assign rsp_data = rsp_ff;

endmodule
`default_nettype wire

// File: hw/rtl/lru_key_value_cache.sv
// An accepted request is registered, its lookup results are captured in the match state and
// its response is registered in the commit state, which waits on a held response. A new
// request is taken only when idle or at commit, as the next lookup must see the update done.
// Reset clears all entries, the count and the ranks at once, and sets capacity to 16.
// The configuration port is always ready.
`default_nettype none
module lru_key_value_cache #(
   parameter int DEPTH = 16
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   output logic                                 req_stall,
   input  wire lkv_pkg::req_type                req_data,
   output logic                                 rsp_valid,
   input  wire logic                            rsp_stall,
   output lkv_pkg::rsp_type                     rsp_data,
   input  wire logic                            csr_valid,
   output logic                                 csr_ready,
   input  wire logic [lkv_pkg::CAP_WIDTH-1:0]   csr_data
);

   lkv_pkg::ctl_type ctl;

   assign csr_ready = 1'b1;

   lkv_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .ctl       (ctl)
   );

   lkv_datapath #(
      .DEPTH (DEPTH)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .ctl       (ctl),
      .req_data  (req_data),
      .rsp_data  (rsp_data),
      .csr_write (csr_valid && csr_ready),
      .csr_data  (csr_data)
   );

endmodule
`default_nettype wire
